// ----- hw/rtl/hcd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types and constants for the header and chunk deframer.
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam logic [7:0] START_KEY   = 8'h0D;
  localparam logic [7:0] END_KEY     = 8'h0A;
  localparam logic [7:0] HEADER_LAST = 8'd5;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_HEADER   = 2'd1,
    EV_GOOD_END = 2'd2,
    EV_BAD_END  = 2'd3
  } hcd_event_t;

  typedef struct packed {
    hcd_event_t  event_res;
    logic        byte_valid;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic [15:0] total_chunks;
    logic [15:0] last_chunk_bytes;
  } hcd_result_t;

endpackage

// ----- hw/rtl/hcd_if.sv -----
// ----------------------------------------------------------------------------
// hcd_in_if / hcd_out_if
// Valid/ready channels for received bytes and deframer results.
// ----------------------------------------------------------------------------
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface hcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic        byte_valid;
  logic [7:0]  byte_index;
  logic [7:0]  byte_value;
  logic [15:0] total_chunks;
  logic [15:0] last_chunk_bytes;

  modport source (output valid, output event_res, output byte_valid, output byte_index,
                  output byte_value, output total_chunks, output last_chunk_bytes,
                  input ready);
  modport sink   (input valid, input event_res, input byte_valid, input byte_index,
                  input byte_value, input total_chunks, input last_chunk_bytes,
                  output ready);
endinterface

// ----- hw/rtl/hcd_frame_fsm.sv -----
// ----------------------------------------------------------------------------
// hcd_frame_fsm
// Header hunt, chunk framing state and per-word result computation.
// ----------------------------------------------------------------------------
module hcd_frame_fsm
  import hcd_pkg::*;
#(
  parameter int CHUNK_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  byte_in,
  output hcd_result_t result
);

  localparam logic [8:0] LAST_POS = 9'(CHUNK_BYTES - 1);

  logic        chunk_mode_r, chunk_mode_nxt;
  logic        hunting_r, hunting_nxt;
  logic [7:0]  position_r, position_nxt;
  logic [7:0]  hdr_r   [4];
  logic [7:0]  hdr_nxt [4];
  logic [15:0] count_r, count_nxt;
  logic [15:0] size_r, size_nxt;
  logic [8:0]  pos_inc;
  logic [1:0]  hdr_idx;

  assign pos_inc = {1'b0, position_r} + 9'd1;
  assign hdr_idx = pos_inc[1:0] - 2'd1;

  always_comb begin
    chunk_mode_nxt = chunk_mode_r;
    hunting_nxt    = hunting_r;
    position_nxt   = position_r;
    hdr_nxt        = hdr_r;
    count_nxt      = count_r;
    size_nxt       = size_r;
    result         = '0;
    result.event_res = EV_NONE;
    if (!chunk_mode_r) begin
      if (hunting_r) begin
        if (byte_in == START_KEY) begin
          hunting_nxt  = 1'b0;
          position_nxt = '0;
        end
      end else if (pos_inc < {1'b0, HEADER_LAST}) begin
        position_nxt     = pos_inc[7:0];
        hdr_nxt[hdr_idx] = byte_in;
      end else begin
        if (byte_in == END_KEY) begin
          count_nxt        = {hdr_r[1], hdr_r[0]};
          size_nxt         = {hdr_r[3], hdr_r[2]};
          chunk_mode_nxt   = 1'b1;
          result.event_res = EV_HEADER;
        end
        hunting_nxt  = 1'b1;
        position_nxt = '0;
      end
    end else begin
      if (hunting_r) begin
        if (byte_in == START_KEY) begin
          hunting_nxt       = 1'b0;
          position_nxt      = '0;
          result.byte_valid = 1'b1;
          result.byte_value = byte_in;
        end
      end else begin
        position_nxt      = pos_inc[7:0];
        result.byte_valid = 1'b1;
        result.byte_index = pos_inc[7:0];
        result.byte_value = byte_in;
        if (pos_inc >= LAST_POS) begin
          result.event_res = (byte_in == END_KEY) ? EV_GOOD_END : EV_BAD_END;
          hunting_nxt      = 1'b1;
          position_nxt     = '0;
        end
      end
    end
    result.total_chunks     = count_nxt;
    result.last_chunk_bytes = size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_mode_r <= 1'b0;
      hunting_r    <= 1'b1;
      position_r   <= '0;
      hdr_r        <= '{default: '0};
      count_r      <= '0;
      size_r       <= '0;
    end else if (accept) begin
      chunk_mode_r <= chunk_mode_nxt;
      hunting_r    <= hunting_nxt;
      position_r   <= position_nxt;
      hdr_r        <= hdr_nxt;
      count_r      <= count_nxt;
      size_r       <= size_nxt;
    end
  end

endmodule

// ----- hw/rtl/hcd_out_buf.sv -----
// ----------------------------------------------------------------------------
// hcd_out_buf
// Result register with one skid entry; takes one more result during a stall.
// ----------------------------------------------------------------------------
module hcd_out_buf
  import hcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  hcd_result_t push_data,
  output logic        push_ready,
  output logic        pop_valid,
  input  logic        pop_ready,
  output hcd_result_t pop_data
);

  logic        main_v_r, main_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  hcd_result_t main_r, main_nxt;
  hcd_result_t skid_r, skid_nxt;
  logic        pop;

  assign pop        = main_v_r && pop_ready;
  assign push_ready = !skid_v_r;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = push_data;
        main_v_nxt = push;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- hw/rtl/header_and_chunk_deframer.sv -----
// ----------------------------------------------------------------------------
// header_and_chunk_deframer
// Serial byte deframer: six-byte header hunt, then fixed-length chunk frames.
//
// in_ch takes one received byte per word. Every accepted word yields exactly
// one result word on out_ch: the event code, the stored chunk byte with its
// index, and the chunk count and last-chunk size latched from the header.
// Throughput is one word per cycle while out_ch does not stall; the framing
// state updates in a single pass per byte. A synchronous low rst_n returns to
// header hunting with all latched values zero and drops any pending results.
// When the receiver stalls, one result waits in the output register and one
// more in a skid entry; in_ch.ready falls only once both are full, and no
// result is lost.
// ----------------------------------------------------------------------------
module header_and_chunk_deframer
  import hcd_pkg::*;
#(
  parameter int CHUNK_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  hcd_in_if.sink    in_ch,
  hcd_out_if.source out_ch
);

  logic        accept;
  hcd_result_t result;
  hcd_result_t out_data;

  assign accept = in_ch.valid && in_ch.ready;

  hcd_frame_fsm #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .byte_in(in_ch.byte_in),
    .result (result)
  );

  hcd_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .push_ready(in_ch.ready),
    .pop_valid (out_ch.valid),
    .pop_ready (out_ch.ready),
    .pop_data  (out_data)
  );

  assign out_ch.event_res        = out_data.event_res;
  assign out_ch.byte_valid       = out_data.byte_valid;
  assign out_ch.byte_index       = out_data.byte_index;
  assign out_ch.byte_value       = out_data.byte_value;
  assign out_ch.total_chunks     = out_data.total_chunks;
  assign out_ch.last_chunk_bytes = out_data.last_chunk_bytes;

endmodule
